// ===== hdl/qpd_pkg.sv =====
package qpd_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } qpd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       is_terminator;
    logic       truncated;
  } qpd_out_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_Q_MODE    = 1'b0,
    CFG_OUT_LIMIT = 1'b1
  } qpd_cfg_idx_t;

  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 16;
  localparam int MAX_RES    = 4;
  localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W  = $clog2(MAX_RES);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_US  = 8'h5F;

  localparam logic                  Q_MODE_RST    = 1'b1;
  localparam logic [CNT_W-1:0]      OUT_LIMIT_RST = 16'hFFFF;

  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    return v[3:0];
  endfunction

endpackage

// ===== hdl/quoted_printable_decoder.sv =====
// Quoted-printable decoder, one encoded byte per input beat. "=XX" (hex of either case) gives
// one byte, "_" gives a space when q_mode is set, and outside q_mode the soft breaks "=CRLF",
// "=CR" and "=LF" give nothing; a bad escape is passed through literally. A zero byte ends the
// text, and the beat with in_last set flushes any open escape and closes with a terminator
// result (out_byte zero), after which the text state clears. Decoded bytes beyond out_limit are
// dropped and flagged in truncated. Each input beat yields zero to four results, the last one
// marked run_end. The block takes one input beat per cycle while each beat yields at most one
// result and out_stall is low; a beat's results fill the four-entry result buffer, which
// drains one result per cycle while out_stall is low. A beat is held in in_hold_r, then its
// results in res_r. Write configuration only while the block is idle; cfg_ready is always high.
module quoted_printable_decoder
  import qpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  qpd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output qpd_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  qpd_cfg_idx_t          cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_EQ   = 2'd1,
    PH_HEX  = 2'd2,
    PH_CR   = 2'd3
  } phase_t;

  logic                 q_mode_r;
  logic [CNT_W-1:0]     out_limit_r;

  logic                 in_vld_r;
  qpd_in_t              in_hold_r;

  phase_t               phase_r, phase_nxt;
  logic [7:0]           held_r, held_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 ended_r, ended_nxt;
  logic                 drop_r, drop_nxt;

  qpd_out_t             res_r [MAX_RES];
  logic [RES_CNT_W-1:0] res_cnt_r;

  qpd_out_t             ent [MAX_RES];
  logic [7:0]           cand [MAX_RES];
  logic [RES_IDX_W-1:0] k;
  logic [RES_IDX_W-1:0] n_emit;
  logic [RES_CNT_W-1:0] n_total;
  logic [CNT_W-1:0]     room;
  logic                 do_fresh;
  logic                 trunc_term;

  logic                 out_pop;
  logic                 buf_free;
  logic                 proc_go;
  logic                 in_take;

  assign cfg_ready = 1'b1;
  assign out_valid = (res_cnt_r != '0);
  assign out_data  = res_r[0];
  assign out_pop   = out_valid && !out_stall;
  assign buf_free  = (res_cnt_r == '0) ||
                     ((res_cnt_r == RES_CNT_W'(1)) && out_pop);
  assign proc_go   = in_vld_r && buf_free;
  assign in_stall  = in_vld_r && !buf_free;
  assign in_take   = in_valid && !in_stall;

  // Decode one held beat into up to three candidate bytes plus the next text state
  always_comb begin
    logic [7:0] c;
    logic       last;
    c          = in_hold_r.in_byte;
    last       = in_hold_r.in_last;
    phase_nxt  = phase_r;
    held_nxt   = held_r;
    ended_nxt  = ended_r;
    do_fresh   = 1'b0;
    k          = '0;
    for (int j = 0; j < MAX_RES; j++) begin
      cand[j] = CH_NUL;
    end

    if (!ended_r) begin
      phase_nxt = PH_IDLE;
      unique case (phase_r)
        PH_EQ: begin
          if (!q_mode_r && c == CH_CR) begin
            phase_nxt = PH_CR;
          end else if (!q_mode_r && c == CH_LF) begin
            phase_nxt = PH_IDLE;
          end else if (hex_ok(c)) begin
            held_nxt  = c;
            phase_nxt = PH_HEX;
          end else begin
            cand[k]  = CH_EQ;
            k        = k + 1'b1;
            do_fresh = 1'b1;
          end
        end
        PH_HEX: begin
          if (hex_ok(c)) begin
            cand[k] = {hex_nib(held_r), hex_nib(c)};
            k       = k + 1'b1;
          end else begin
            cand[k]  = CH_EQ;
            k        = k + 1'b1;
            cand[k]  = held_r;
            k        = k + 1'b1;
            do_fresh = 1'b1;
          end
        end
        PH_CR: begin
          do_fresh = (c != CH_LF);
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase

      if (do_fresh) begin
        if (c == CH_NUL) begin
          ended_nxt = 1'b1;
        end else if (c == CH_EQ) begin
          phase_nxt = PH_EQ;
        end else begin
          cand[k] = (q_mode_r && c == CH_US) ? CH_SP : c;
          k       = k + 1'b1;
        end
      end
      if (ended_nxt) begin
        phase_nxt = PH_IDLE;
      end
    end

    // Flush an open escape on the final beat
    if (last) begin
      if (phase_nxt == PH_EQ) begin
        cand[k] = CH_EQ;
        k       = k + 1'b1;
      end else if (phase_nxt == PH_HEX) begin
        cand[k] = CH_EQ;
        k       = k + 1'b1;
        cand[k] = held_nxt;
        k       = k + 1'b1;
      end
    end
  end

  // Apply the output limit and lay out the result entries
  always_comb begin
    room       = (out_limit_r > count_r) ? (out_limit_r - count_r) : '0;
    n_emit     = (room >= CNT_W'(k)) ? k : room[RES_IDX_W-1:0];
    count_nxt  = count_r + CNT_W'(n_emit);
    drop_nxt   = drop_r || (k != n_emit);
    trunc_term = drop_nxt;
    n_total    = RES_CNT_W'(n_emit) + RES_CNT_W'(in_hold_r.in_last);

    for (int j = 0; j < MAX_RES; j++) begin
      ent[j].out_byte      = (RES_CNT_W'(j) < RES_CNT_W'(n_emit)) ? cand[j] : CH_NUL;
      ent[j].is_terminator = (RES_CNT_W'(j) == RES_CNT_W'(n_emit)) && in_hold_r.in_last;
      ent[j].truncated     = ent[j].is_terminator ? trunc_term : drop_r;
      ent[j].run_end       = (RES_CNT_W'(j + 1) == n_total);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_mode_r    <= Q_MODE_RST;
      out_limit_r <= OUT_LIMIT_RST;
      in_vld_r    <= 1'b0;
      phase_r     <= PH_IDLE;
      held_r      <= '0;
      count_r     <= '0;
      ended_r     <= 1'b0;
      drop_r      <= 1'b0;
      res_cnt_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_Q_MODE:    q_mode_r    <= cfg_data[0];
          CFG_OUT_LIMIT: out_limit_r <= cfg_data[CNT_W-1:0];
          default:       ;
        endcase
      end

      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (proc_go) begin
        in_vld_r <= 1'b0;
      end

      if (proc_go) begin
        if (in_hold_r.in_last) begin
          // Terminator closes the text: start the next one clean
          phase_r <= PH_IDLE;
          held_r  <= '0;
          count_r <= '0;
          ended_r <= 1'b0;
          drop_r  <= 1'b0;
        end else begin
          phase_r <= phase_nxt;
          held_r  <= held_nxt;
          count_r <= count_nxt;
          ended_r <= ended_nxt;
          drop_r  <= drop_nxt;
        end
        res_cnt_r <= n_total;
      end else if (out_pop) begin
        res_cnt_r <= res_cnt_r - 1'b1;
      end
    end

    if (in_take) begin
      in_hold_r <= in_data;
    end

    if (proc_go) begin
      for (int j = 0; j < MAX_RES; j++) begin
        res_r[j] <= ent[j];
      end
    end else if (out_pop) begin
      // Advance the result queue by one beat
      for (int j = 0; j < MAX_RES - 1; j++) begin
        res_r[j] <= res_r[j+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_res_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= RES_CNT_W'(MAX_RES))
    else $error("result buffer count out of range");

  a_term_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_terminator |-> out_data.run_end)
    else $error("terminator not marked as end of run");

  a_stall_needs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && res_cnt_r != '0)
    else $error("input stalled with nothing pending");

  a_ended_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> phase_r == PH_IDLE)
    else $error("escape open after end of text");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop && !proc_go |=> res_cnt_r == $past(res_cnt_r) - 1'b1)
    else $error("result buffer did not advance on output beat");
`endif

endmodule

// ===== test/quoted_printable_decoder_tb.sv =====
`timescale 1ns / 1ps

module quoted_printable_decoder_tb;
  import qpd_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 64;
  localparam int PHASE_BEATS   = 100;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_EQ    = 2'd1,
    ESC_DIGIT = 2'd2,
    ESC_CR    = 2'd3
  } esc_t;

  // One line of the directed plan: a beat, or a write of both registers.
  // known_n < 0 means the beat is checked against the decoder model.
  typedef struct {
    bit          is_cfg;
    logic        q;
    logic [15:0] lim;
    logic [7:0]  ch;
    logic        lst;
    int          known_n;
    logic [7:0]  kb0;
    logic [7:0]  kb1;
    logic        kterm;
    logic        ktrunc;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  qpd_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  qpd_out_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  qpd_cfg_idx_t          cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Decoder model state
  logic        dec_q_mode;
  logic [15:0] dec_limit;
  esc_t        dec_phase;
  logic [7:0]  dec_held;
  logic [15:0] dec_count;
  logic        dec_ended;
  logic        dec_dropped;
  qpd_out_t    beat_res [MAX_RES];
  int          beat_n;

  qpd_out_t    decoded_q [$];
  qpd_out_t    want;
  int          bad_results;
  int          idle_pct;
  int          stall_pct;
  int          beats_sent;
  int          hold_asks;
  int          hold_served;
  int          hold_left;
  plan_row_t   plan [$];

  quoted_printable_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("quoted_printable_decoder regression: fail");
    $finish;
  end

  function automatic bit is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Letters of either case carry their value in the low nibble plus nine.
  function automatic logic [3:0] hex_val(logic [7:0] c);
    return (c <= "9") ? c[3:0] : c[3:0] + 4'd9;
  endfunction

  function automatic void add_result(logic [7:0] ch, logic term);
    beat_res[beat_n].out_byte      = ch;
    beat_res[beat_n].run_end       = 1'b0;
    beat_res[beat_n].is_terminator = term;
    beat_res[beat_n].truncated     = dec_dropped;
    beat_n++;
  endfunction

  function automatic void emit(logic [7:0] ch);
    if (dec_count < dec_limit) begin
      dec_count++;
      add_result(ch, 1'b0);
    end else begin
      dec_dropped = 1'b1;
    end
  endfunction

  function automatic void plain_char(logic [7:0] c);
    if (c == CH_NUL) begin
      dec_ended = 1'b1;
    end else if (c == CH_EQ) begin
      dec_phase = ESC_EQ;
    end else if (dec_q_mode && c == CH_US) begin
      emit(CH_SP);
    end else begin
      emit(c);
    end
  endfunction

  function automatic void escape_char(logic [7:0] c);
    case (dec_phase)
      ESC_EQ: begin
        if (!dec_q_mode && c == CH_CR) begin
          dec_phase = ESC_CR;
        end else if (!dec_q_mode && c == CH_LF) begin
          dec_phase = ESC_IDLE;
        end else if (is_hex(c)) begin
          dec_held  = c;
          dec_phase = ESC_DIGIT;
        end else begin
          dec_phase = ESC_IDLE;
          emit(CH_EQ);
          plain_char(c);
        end
      end
      ESC_DIGIT: begin
        dec_phase = ESC_IDLE;
        if (is_hex(c)) begin
          emit({hex_val(dec_held), hex_val(c)});
        end else begin
          emit(CH_EQ);
          emit(dec_held);
          plain_char(c);
        end
      end
      ESC_CR: begin
        dec_phase = ESC_IDLE;
        if (c != CH_LF) plain_char(c);
      end
      default: begin
        dec_phase = ESC_IDLE;
        plain_char(c);
      end
    endcase
  endfunction

  function automatic void clear_text();
    dec_phase   = ESC_IDLE;
    dec_held    = 8'h00;
    dec_count   = 16'd0;
    dec_ended   = 1'b0;
    dec_dropped = 1'b0;
  endfunction

  // Advance the model by one accepted beat; results land in beat_res.
  function automatic void decode_beat(qpd_in_t b);
    beat_n = 0;
    if (!dec_ended) begin
      escape_char(b.in_byte);
      if (dec_ended) dec_phase = ESC_IDLE;
    end
    if (b.in_last) begin
      if (dec_phase == ESC_EQ) begin
        emit(CH_EQ);
      end else if (dec_phase == ESC_DIGIT) begin
        emit(CH_EQ);
        emit(dec_held);
      end
      dec_phase = ESC_IDLE;
      add_result(CH_NUL, 1'b1);
      clear_text();
    end
    if (beat_n > 0) beat_res[beat_n-1].run_end = 1'b1;
  endfunction

  function automatic void queue_decoded();
    for (int i = 0; i < beat_n; i++) decoded_q.push_back(beat_res[i]);
  endfunction

  function automatic void queue_known(plan_row_t r);
    qpd_out_t e;
    for (int i = 0; i < r.known_n; i++) begin
      e.out_byte      = (i == 0) ? r.kb0 : r.kb1;
      e.run_end       = (i == r.known_n - 1);
      e.is_terminator = (i == r.known_n - 1) && r.kterm;
      e.truncated     = r.ktrunc;
      decoded_q.push_back(e);
    end
  endfunction

  function automatic plan_row_t beat_row(logic [7:0] ch, logic lst);
    plan_row_t r;
    r = '{default: '0};
    r.ch      = ch;
    r.lst     = lst;
    r.known_n = -1;
    return r;
  endfunction

  function automatic plan_row_t known_row(logic [7:0] ch, logic lst, int n, logic [7:0] b0,
                                          logic [7:0] b1, logic term, logic trunc);
    plan_row_t r;
    r = beat_row(ch, lst);
    r.known_n = n;
    r.kb0     = b0;
    r.kb1     = b1;
    r.kterm   = term;
    r.ktrunc  = trunc;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(logic q, logic [15:0] lim);
    plan_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.q      = q;
    r.lim    = lim;
    return r;
  endfunction

  function automatic logic [7:0] rand_hex();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return 8'("0" + k);
    if (k < 16) return 8'("A" + k - 10);
    return 8'("a" + k - 16);
  endfunction

  // Offer one beat, with random idle cycles ahead of it, and return once it is taken.
  task automatic push_beat(qpd_in_t b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    decode_beat(b);
    beats_sent++;
  endtask

  // Wait for the block to drain, including beats that give no result.
  task automatic settle();
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back, valid held high across the two beats.
  task automatic configure(logic q, logic [15:0] lim);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_Q_MODE;
    cfg_data  <= {15'd0, q};
    do @(posedge clk); while (!cfg_ready);
    dec_q_mode = q;
    cfg_index <= CFG_OUT_LIMIT;
    cfg_data  <= lim;
    do @(posedge clk); while (!cfg_ready);
    dec_limit = lim;
    cfg_valid <= 1'b0;
  endtask

  // One encoded text: mostly well-formed tokens, some noise, always closed by in_last.
  task automatic run_text();
    logic [7:0] txt [$];
    int         ntok;
    qpd_in_t    b;
    ntok = $urandom_range(1, 8);
    repeat (ntok) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
        5: txt.push_back(CH_US);
        6, 7: begin
          txt.push_back(CH_EQ);
          txt.push_back(rand_hex());
          txt.push_back(rand_hex());
        end
        8: begin
          txt.push_back(CH_EQ);
          txt.push_back(CH_CR);
          txt.push_back(CH_LF);
        end
        9: begin
          txt.push_back(CH_EQ);
          txt.push_back(CH_CR);
        end
        10: begin
          txt.push_back(CH_EQ);
          txt.push_back(CH_LF);
        end
        11: begin
          txt.push_back(CH_EQ);
          txt.push_back(8'($urandom_range(255)));
        end
        12: begin
          txt.push_back(CH_EQ);
          txt.push_back(rand_hex());
          txt.push_back(8'($urandom_range(255)));
        end
        13: txt.push_back(8'($urandom_range(255)));
        14: txt.push_back(CH_NUL);
        default: txt.push_back(CH_EQ);
      endcase
    end
    // cut the text short now and then so in_last lands inside an escape
    if ($urandom_range(3) == 0 && txt.size() > 1) void'(txt.pop_back());
    for (int k = 0; k < txt.size(); k++) begin
      b.in_byte = txt[k];
      b.in_last = (k == txt.size() - 1);
      push_beat(b);
      queue_decoded();
    end
  endtask

  task automatic run_phase(int idle, int stall, logic q, logic [15:0] lim, bit hold);
    settle();
    configure(q, lim);
    idle_pct  = idle;
    stall_pct = stall;
    if (hold) hold_asks++;
    beats_sent = 0;
    while (beats_sent < PHASE_BEATS) run_text();
    in_valid <= 1'b0;
  endtask

  // Receiver: random stall, or a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served <= hold_asks;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected result: byte=%h end=%b term=%b trunc=%b", out_data.out_byte,
                   out_data.run_end, out_data.is_terminator, out_data.truncated);
      end else begin
        want = decoded_q.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.run_end !== want.run_end ||
            out_data.is_terminator !== want.is_terminator ||
            out_data.truncated !== want.truncated) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: want byte=%h end=%b term=%b trunc=%b, saw byte=%h end=%b term=%b trunc=%b",
                     want.out_byte, want.run_end, want.is_terminator, want.truncated,
                     out_data.out_byte, out_data.run_end, out_data.is_terminator,
                     out_data.truncated);
        end
      end
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_Q_MODE;
    cfg_data    = '0;
    out_stall   = 1'b0;
    bad_results = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    beats_sent  = 0;
    hold_asks   = 0;
    hold_served = 0;
    hold_left   = 0;
    dec_q_mode  = Q_MODE_RST;
    dec_limit   = OUT_LIMIT_RST;
    clear_text();

    // Reset values first: Q mode, no limit in practice
    plan.push_back(known_row(8'hFF, 1'b0, 1, 8'hFF, 8'h00, 1'b0, 1'b0));
    plan.push_back(known_row(CH_US, 1'b0, 1, CH_SP, 8'h00, 1'b0, 1'b0));
    plan.push_back(known_row(CH_EQ, 1'b0, 0, 8'h00, 8'h00, 1'b0, 1'b0));
    plan.push_back(known_row("4", 1'b0, 0, 8'h00, 8'h00, 1'b0, 1'b0));
    plan.push_back(known_row("f", 1'b0, 1, 8'h4F, 8'h00, 1'b0, 1'b0));
    plan.push_back(known_row(CH_EQ, 1'b0, 0, 8'h00, 8'h00, 1'b0, 1'b0));
    plan.push_back(known_row("G", 1'b0, 2, CH_EQ, "G", 1'b0, 1'b0));
    plan.push_back(beat_row(CH_EQ, 1'b0));
    plan.push_back(beat_row("a", 1'b1));
    plan.push_back(known_row(CH_NUL, 1'b1, 1, CH_NUL, 8'h00, 1'b1, 1'b0));
    // Body mode with a tiny limit: soft breaks and truncation
    plan.push_back(cfg_row(1'b0, 16'd2));
    plan.push_back(beat_row(CH_EQ, 1'b0));
    plan.push_back(beat_row(CH_CR, 1'b0));
    plan.push_back(beat_row(CH_LF, 1'b0));
    plan.push_back(beat_row(CH_EQ, 1'b0));
    plan.push_back(beat_row(CH_LF, 1'b0));
    plan.push_back(beat_row(CH_EQ, 1'b0));
    plan.push_back(beat_row(CH_CR, 1'b0));
    plan.push_back(beat_row(CH_US, 1'b0));
    plan.push_back(beat_row("B", 1'b0));
    plan.push_back(beat_row("C", 1'b0));
    plan.push_back(beat_row(CH_NUL, 1'b0));
    plan.push_back(known_row("x", 1'b1, 1, CH_NUL, 8'h00, 1'b1, 1'b1));
    // Soft break left open across a switch to Q mode, then zero inside an escape
    plan.push_back(cfg_row(1'b0, 16'hFFFF));
    plan.push_back(beat_row(CH_EQ, 1'b0));
    plan.push_back(beat_row(CH_CR, 1'b0));
    plan.push_back(cfg_row(1'b1, 16'hFFFF));
    plan.push_back(beat_row(CH_LF, 1'b0));
    plan.push_back(beat_row(CH_EQ, 1'b0));
    plan.push_back(beat_row(CH_NUL, 1'b1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        in_valid <= 1'b0;
        settle();
        configure(plan[i].q, plan[i].lim);
      end else begin
        push_beat('{in_byte: plan[i].ch, in_last: plan[i].lst});
        if (plan[i].known_n < 0) queue_decoded();
        else queue_known(plan[i]);
      end
    end
    in_valid <= 1'b0;

    run_phase(0, 0, 1'b1, 16'hFFFF, 1'b1);
    run_phase(78, 0, 1'b0, 16'hFFFF, 1'b0);
    run_phase(0, 78, 1'b0, 16'd1, 1'b0);
    run_phase(38, 38, 1'b1, 16'd5, 1'b0);

    while (decoded_q.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (bad_results == 0) begin
      $display("quoted_printable_decoder regression: pass");
    end else begin
      $display("quoted_printable_decoder regression: fail");
    end
    $finish;
  end

endmodule
